>>> sv/mhe_pkg.sv
// ----------------------------------------------------------------------------
// mhe_pkg
// Shared types and constants of the marked prefix-code encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package mhe_pkg;

   localparam int MAX_CODE_BITS = 32;
   localparam int LEN_CAP       = (MAX_CODE_BITS > 32) ? 32 : MAX_CODE_BITS;
   localparam int TABLE_DEPTH   = 256;
   localparam int SYM_W         = 8;
   localparam int ACC_W         = 40;

   localparam logic [1:0] CMD_LOAD   = 2'd0;
   localparam logic [1:0] CMD_ENCODE = 2'd1;
   localparam logic [1:0] CMD_FLUSH  = 2'd2;

   typedef struct packed {
      logic [1:0]  command;
      logic [7:0]  symbol;
      logic [5:0]  code_length;
      logic [31:0] code_bits;
   } req_type;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic [3:0]  valid_bits;
      logic [31:0] total_bits;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [5:0]  length;
      logic [31:0] code;
   } entry_type;

   typedef struct packed {
      logic             en;
      logic [SYM_W-1:0] addr;
      entry_type        entry;
   } tbl_wr_type;

   typedef struct packed {
      logic             en;
      logic [SYM_W-1:0] addr;
   } tbl_rd_type;

endpackage

`default_nettype wire

>>> sv/mhe_table.sv
// ----------------------------------------------------------------------------
// mhe_table
// Code table memory with one write and one registered read port; entries
// never written since reset read as length zero.
// ----------------------------------------------------------------------------
`default_nettype none

module mhe_table
   import mhe_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire tbl_wr_type wr,
   input  wire tbl_rd_type rd,
   output entry_type       rd_entry
);

   entry_type              table_mem_ff [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0] valid_ff;
   entry_type              rd_entry_ff;
   logic                   rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         table_mem_ff[wr.addr] <= wr.entry;
      end
      if (rd.en) begin
         rd_entry_ff <= table_mem_ff[rd.addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr.en) begin
            valid_ff[wr.addr] <= 1'b1;
         end
         if (rd.en) begin
            rd_valid_ff <= valid_ff[rd.addr];
         end
      end
   end

   assign rd_entry = rd_valid_ff ? rd_entry_ff : '0;

endmodule

`default_nettype wire

>>> sv/mhe_packer.sv
// ----------------------------------------------------------------------------
// mhe_packer
// Command sequencer and bit packer: looks up codes, appends code and marker
// bits to the pending bits, emits completed bytes one per cycle and flushes the rest.
// ----------------------------------------------------------------------------
`default_nettype none

module mhe_packer
   import mhe_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      start,
   input  wire req_type   req,
   output logic           busy,
   output tbl_wr_type     tbl_wr,
   output tbl_rd_type     tbl_rd,
   input  wire entry_type rd_entry,
   output logic           strobe,
   output rsp_type        rsp
);

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_LOOKUP = 4'b0010,
      S_ALIGN  = 4'b0100,
      S_EMIT   = 4'b1000
   } state_type;

   state_type        state_ff, state_in;
   logic [6:0]       pend_bits_ff, pend_bits_in;
   logic [2:0]       pend_cnt_ff, pend_cnt_in;
   logic [31:0]      total_ff, total_in;
   logic [ACC_W-1:0] acc_ff, acc_in;
   logic [5:0]       nbits_ff, nbits_in;
   logic [ACC_W-1:0] word_ff, word_in;
   logic [2:0]       byte_cnt_ff, byte_cnt_in;
   logic             strobe_ff, strobe_in;
   rsp_type          rsp_ff, rsp_in;

   logic             accept;
   logic [5:0]       len;
   logic [32:0]      mask33;
   logic [31:0]      code_m;
   logic [32:0]      total_sum;
   logic [5:0]       shamt;
   logic [7:0]       rmask;
   logic [15:0]      flush_byte;

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;

   always_comb begin
      tbl_wr.en          = accept && (req.command == CMD_LOAD);
      tbl_wr.addr        = req.symbol;
      tbl_wr.entry.code  = req.code_bits;
      tbl_wr.entry.length = (req.code_length > 6'(LEN_CAP)) ? 6'(LEN_CAP)
                                                             : req.code_length;
      tbl_rd.en          = accept && (req.command == CMD_ENCODE);
      tbl_rd.addr        = req.symbol;
   end

   always_comb begin
      len        = (rd_entry.length > 6'd32) ? 6'd32 : rd_entry.length;
      mask33     = (33'd1 << len) - 33'd1;
      code_m     = rd_entry.code & mask33[31:0];
      total_sum  = {1'b0, total_ff} + {27'd0, len} + 33'd1;
      shamt      = 6'(ACC_W) - nbits_ff;
      rmask      = (8'd1 << nbits_ff[2:0]) - 8'd1;
      flush_byte = {9'd0, pend_bits_ff} << (4'd8 - {1'b0, pend_cnt_ff});
   end

   always_comb begin
      state_in     = state_ff;
      pend_bits_in = pend_bits_ff;
      pend_cnt_in  = pend_cnt_ff;
      total_in     = total_ff;
      acc_in       = acc_ff;
      nbits_in     = nbits_ff;
      word_in      = word_ff;
      byte_cnt_in  = byte_cnt_ff;
      strobe_in    = 1'b0;
      rsp_in       = rsp_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept && (req.command == CMD_ENCODE)) begin
               state_in = S_LOOKUP;
            end else if (accept && (req.command == CMD_FLUSH)) begin
               strobe_in         = 1'b1;
               rsp_in.out_byte   = flush_byte[7:0];
               rsp_in.valid_bits = {1'b0, pend_cnt_ff};
               rsp_in.total_bits = total_ff;
               rsp_in.last       = 1'b1;
               pend_bits_in      = '0;
               pend_cnt_in       = '0;
               total_in          = '0;
            end
         end
         S_LOOKUP: begin
            acc_in   = ({33'd0, pend_bits_ff} << (len + 6'd1))
                       | {7'd0, code_m, 1'b1};
            nbits_in = {3'd0, pend_cnt_ff} + len + 6'd1;
            total_in = total_sum[32] ? '1 : total_sum[31:0];
            state_in = S_ALIGN;
         end
         S_ALIGN: begin
            word_in      = acc_ff << shamt;
            byte_cnt_in  = nbits_ff[5:3];
            pend_bits_in = acc_ff[6:0] & rmask[6:0];
            pend_cnt_in  = nbits_ff[2:0];
            state_in     = (nbits_ff[5:3] == 3'd0) ? S_IDLE : S_EMIT;
         end
         S_EMIT: begin
            strobe_in         = 1'b1;
            rsp_in.out_byte   = word_ff[ACC_W-1 -: 8];
            rsp_in.valid_bits = 4'd8;
            rsp_in.total_bits = '0;
            rsp_in.last       = (byte_cnt_ff == 3'd1);
            word_in           = word_ff << 8;
            byte_cnt_in       = byte_cnt_ff - 3'd1;
            if (byte_cnt_ff == 3'd1) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pend_bits_ff <= '0;
         pend_cnt_ff  <= '0;
         total_ff     <= '0;
         strobe_ff    <= 1'b0;
         byte_cnt_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         pend_bits_ff <= pend_bits_in;
         pend_cnt_ff  <= pend_cnt_in;
         total_ff     <= total_in;
         strobe_ff    <= strobe_in;
         byte_cnt_ff  <= byte_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff   <= acc_in;
      nbits_ff <= nbits_in;
      word_ff  <= word_in;
      rsp_ff   <= rsp_in;
   end

   assign strobe = strobe_ff;
   assign rsp    = rsp_ff;

endmodule

`default_nettype wire

>>> sv/marked_huffman_encoder_top.sv
// ----------------------------------------------------------------------------
// marked_huffman_encoder_top
// Prefix-code encoder with a 1 marker bit after each code word.
// load: no response; flush: one response the cycle after accept
// encode: table read and bit alignment, then one response per completed byte
//   (0 to 5 bytes); no new request is accepted until the encode completes
// responses are strobed for one cycle; the receiver cannot stall
// synchronous reset clears the packer, the bit count and all table entries
// ----------------------------------------------------------------------------
`default_nettype none

module marked_huffman_encoder_top
   import mhe_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_payload,
   output logic         rsp_strobe,
   output rsp_type      rsp_payload
);

   tbl_wr_type tbl_wr;
   tbl_rd_type tbl_rd;
   entry_type  rd_entry;

   mhe_table u_table (
      .clock    (clock),
      .reset    (reset),
      .wr       (tbl_wr),
      .rd       (tbl_rd),
      .rd_entry (rd_entry)
   );

   mhe_packer u_packer (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req      (req_payload),
      .busy     (busy),
      .tbl_wr   (tbl_wr),
      .tbl_rd   (tbl_rd),
      .rd_entry (rd_entry),
      .strobe   (rsp_strobe),
      .rsp      (rsp_payload)
   );

endmodule

`default_nettype wire
